@@ hdl/tes_pkg.sv @@
// Shared widths, payload types and status codes for the triangle edge setup block.
// Used by tes_div_stage and triangle_edge_setup; depends on nothing.
package tes_pkg;

	localparam int COORD_BITS      = 16;
	localparam int RECIP_FRAC_BITS = 30;

	localparam int EDGE_W    = COORD_BITS + 1;
	localparam int PROD_W    = 2 * EDGE_W;
	localparam int DET_W     = PROD_W + 1;
	localparam int QUO_W     = RECIP_FRAC_BITS + 1;
	localparam int DIV_STEPS = RECIP_FRAC_BITS;

	localparam int HALF_W = 16;
	localparam int WORD_W = 32;
	localparam int CODE_W = 12;
	localparam int TAG_W  = 32;
	localparam int STAT_W = 2;

	localparam int IN_FIELDS_W  = 6 * COORD_BITS + TAG_W;
	localparam int IN_DATA_W    = 8 * ((IN_FIELDS_W + 7) / 8);
	localparam int OUT_FIELDS_W = 6 * EDGE_W + 3 * WORD_W + CODE_W + STAT_W + TAG_W;
	localparam int OUT_DATA_W   = 8 * ((OUT_FIELDS_W + 7) / 8);

	typedef enum logic [STAT_W-1:0] {
		ST_FRONT = 2'd0,
		ST_BACK  = 2'd1,
		ST_DEGEN = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [EDGE_W-1:0] b0;
		logic signed [EDGE_W-1:0] c0;
		logic signed [EDGE_W-1:0] b1;
		logic signed [EDGE_W-1:0] c1;
		logic signed [EDGE_W-1:0] b2;
		logic signed [EDGE_W-1:0] c2;
		logic [WORD_W-1:0]        bbox_x;
		logic [WORD_W-1:0]        bbox_y;
		logic [CODE_W-1:0]        codes;
		status_t                  status;
		logic [TAG_W-1:0]         tag;
		logic                     neg;
		logic                     degen;
	} pay_t;

	typedef struct packed {
		logic [DET_W-1:0] rem;
		logic [DET_W-1:0] mag;
		logic [QUO_W-1:0] quo;
	} div_t;

endpackage

@@ hdl/tes_div_stage.sv @@
// One restoring-division step of the reciprocal, registered, with its own handshake.
// Depends on tes_pkg (pay_t, div_t, DET_W, QUO_W).
module tes_div_stage (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  tes_pkg::pay_t in_pay,
	input  tes_pkg::div_t in_div,
	output logic         out_valid,
	input  logic         out_ready,
	output tes_pkg::pay_t out_pay,
	output tes_pkg::div_t out_div
);

	logic                     valid_q;
	tes_pkg::pay_t            pay_q;
	tes_pkg::div_t            div_q;
	tes_pkg::div_t            div_next;
	logic [tes_pkg::DET_W:0]  rem_sh;
	logic [tes_pkg::DET_W:0]  diff;
	logic                     take;

	always_comb begin
		rem_sh = {in_div.rem, 1'b0};
		diff   = rem_sh - {1'b0, in_div.mag};
		take   = !diff[tes_pkg::DET_W];
		div_next.mag = in_div.mag;
		div_next.rem = take ? diff[tes_pkg::DET_W-1:0] : rem_sh[tes_pkg::DET_W-1:0];
		div_next.quo = {in_div.quo[tes_pkg::QUO_W-2:0], take};
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_pay   = pay_q;
	assign out_div   = div_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			pay_q <= in_pay;
			div_q <= div_next;
		end
	end

endmodule

@@ hdl/triangle_edge_setup.sv @@
// Triangle edge setup: edge coefficients, determinant, facing, bbox, corner codes, 1/det.
// Register stages in order: diffs/bbox, products, determinant, sign fix, one
// reciprocal bit per stage, output. One word per cycle when m_tready does not stall.
// The reciprocal chain of tes_div_stage sets the depth. Each stage holds when full
// and stalled, so bubbles fill in. Async reset clears only the valid bits.
module triangle_edge_setup (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// vertex_x0, vertex_y0, vertex_x1, vertex_y1, vertex_x2, vertex_y2, bin_tag
	input  logic [tes_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// edge0_b, edge0_c, edge1_b, edge1_c, edge2_b, edge2_c, inv_det, bbox_x,
	// bbox_y, corner_codes, status, bin_tag_out, zero pad
	output logic [tes_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int CB = tes_pkg::COORD_BITS;
	localparam int EW = tes_pkg::EDGE_W;
	localparam int DW = tes_pkg::DET_W;
	localparam int NS = tes_pkg::DIV_STEPS;

	localparam logic [1:0] CORNER_0 = 2'd0;
	localparam logic [1:0] CORNER_1 = 2'd1;
	localparam logic [1:0] CORNER_2 = 2'd2;
	localparam logic [1:0] CORNER_3 = 2'd3;

	function automatic logic [3:0] corner_pair(input logic signed [EW-1:0] b,
		input logic signed [EW-1:0] c);
		logic       pos_c;
		logic [1:0] rej;
		logic [1:0] acc;
		pos_c = !c[EW-1] && (c != '0);
		if (b[EW-1]) begin
			rej = pos_c ? CORNER_3 : CORNER_1;
			acc = pos_c ? CORNER_0 : CORNER_2;
		end else begin
			rej = pos_c ? CORNER_2 : CORNER_0;
			acc = pos_c ? CORNER_1 : CORNER_3;
		end
		return {acc, rej};
	endfunction

	// stage 1: differences and bounding box
	logic signed [CB-1:0] vx [3];
	logic signed [CB-1:0] vy [3];
	logic signed [CB-1:0] max_x, min_x, max_y, min_y;
	logic signed [CB-1:0] mx01, nx01, my01, ny01;
	tes_pkg::pay_t         pay_d1;

	always_comb begin
		for (int e = 0; e < 3; e++) begin
			vx[e] = s_tdata[(2 * e) * CB +: CB];
			vy[e] = s_tdata[(2 * e + 1) * CB +: CB];
		end
		mx01  = (vx[0] > vx[1]) ? vx[0] : vx[1];
		nx01  = (vx[0] < vx[1]) ? vx[0] : vx[1];
		my01  = (vy[0] > vy[1]) ? vy[0] : vy[1];
		ny01  = (vy[0] < vy[1]) ? vy[0] : vy[1];
		max_x = (mx01 > vx[2]) ? mx01 : vx[2];
		min_x = (nx01 < vx[2]) ? nx01 : vx[2];
		max_y = (my01 > vy[2]) ? my01 : vy[2];
		min_y = (ny01 < vy[2]) ? ny01 : vy[2];

		pay_d1.b0     = EW'(vy[1]) - EW'(vy[0]);
		pay_d1.c0     = EW'(vx[1]) - EW'(vx[0]);
		pay_d1.b1     = EW'(vy[2]) - EW'(vy[1]);
		pay_d1.c1     = EW'(vx[2]) - EW'(vx[1]);
		pay_d1.b2     = EW'(vy[0]) - EW'(vy[2]);
		pay_d1.c2     = EW'(vx[0]) - EW'(vx[2]);
		pay_d1.bbox_x = {tes_pkg::HALF_W'(max_x), tes_pkg::HALF_W'(min_x)};
		pay_d1.bbox_y = {tes_pkg::HALF_W'(max_y), tes_pkg::HALF_W'(min_y)};
		pay_d1.codes  = '0;
		pay_d1.status = tes_pkg::ST_FRONT;
		pay_d1.tag    = s_tdata[6 * CB +: tes_pkg::TAG_W];
		pay_d1.neg    = 1'b0;
		pay_d1.degen  = 1'b0;
	end

	logic                        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic                        rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	tes_pkg::pay_t               pay_s1, pay_s2, pay_s3, pay_s4, pay_s5;
	logic signed [tes_pkg::PROD_W-1:0] p1_s2, p2_s2;
	logic signed [DW-1:0]        det_s3;
	tes_pkg::div_t               div_s4, div_s5;

	logic                        link_valid [NS+1];
	logic                        link_ready [NS+1];
	tes_pkg::pay_t               link_pay   [NS+1];
	tes_pkg::div_t               link_div   [NS+1];

	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign rdy_s4   = !valid_s4 || link_ready[0];
	assign rdy_s5   = !valid_s5 || m_tready;
	assign s_tready = rdy_s1;

	// stage 4: sign fix, corner codes, divider seed
	logic                 neg_d4, degen_d4, unit_d4;
	tes_pkg::pay_t        pay_d4;
	tes_pkg::div_t        div_d4;

	always_comb begin
		neg_d4   = det_s3[DW-1];
		degen_d4 = (det_s3 == '0);
		unit_d4  = (det_s3 == DW'(1)) || (det_s3 == {DW{1'b1}});
		pay_d4   = pay_s3;
		if (neg_d4) begin
			pay_d4.b0 = -pay_s3.b0;
			pay_d4.c0 = -pay_s3.c0;
			pay_d4.b1 = -pay_s3.b1;
			pay_d4.c1 = -pay_s3.c1;
			pay_d4.b2 = -pay_s3.b2;
			pay_d4.c2 = -pay_s3.c2;
		end
		pay_d4.codes = {corner_pair(pay_d4.b2, pay_d4.c2), corner_pair(pay_d4.b1, pay_d4.c1),
			corner_pair(pay_d4.b0, pay_d4.c0)};
		pay_d4.neg   = neg_d4;
		pay_d4.degen = degen_d4;
		if (degen_d4) begin
			pay_d4.status = tes_pkg::ST_DEGEN;
			pay_d4.codes  = '0;
			pay_d4.bbox_x = '0;
			pay_d4.bbox_y = '0;
		end else begin
			pay_d4.status = neg_d4 ? tes_pkg::ST_BACK : tes_pkg::ST_FRONT;
		end
		div_d4.mag = neg_d4 ? DW'(-det_s3) : DW'(det_s3);
		div_d4.rem = DW'(!unit_d4);
		div_d4.quo = tes_pkg::QUO_W'(unit_d4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= s_tvalid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_s5) valid_s5 <= link_valid[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			pay_s1 <= pay_d1;
		end
		if (rdy_s2 && valid_s1) begin
			pay_s2 <= pay_s1;
			p1_s2  <= pay_s1.c2 * pay_s1.b1;
			p2_s2  <= pay_s1.c1 * pay_s1.b2;
		end
		if (rdy_s3 && valid_s2) begin
			pay_s3 <= pay_s2;
			det_s3 <= DW'(p2_s2) - DW'(p1_s2);
		end
		if (rdy_s4 && valid_s3) begin
			pay_s4 <= pay_d4;
			div_s4 <= div_d4;
		end
		if (rdy_s5 && link_valid[NS]) begin
			pay_s5 <= link_pay[NS];
			div_s5 <= link_div[NS];
		end
	end

	assign link_valid[0]  = valid_s4;
	assign link_pay[0]    = pay_s4;
	assign link_div[0]    = div_s4;
	assign link_ready[NS] = rdy_s5;

	for (genvar k = 0; k < NS; k++) begin : g_div
		tes_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[k]),
			.in_ready  (link_ready[k]),
			.in_pay    (link_pay[k]),
			.in_div    (link_div[k]),
			.out_valid (link_valid[k+1]),
			.out_ready (link_ready[k+1]),
			.out_pay   (link_pay[k+1]),
			.out_div   (link_div[k+1])
		);
	end

	// stage 5 (after the divider chain): signed reciprocal and output word
	logic [tes_pkg::WORD_W-1:0] quo_w;
	logic [tes_pkg::WORD_W-1:0] inv_det;

	always_comb begin
		quo_w = tes_pkg::WORD_W'(div_s5.quo);
		if (pay_s5.degen) begin
			inv_det = '0;
		end else begin
			inv_det = pay_s5.neg ? -quo_w : quo_w;
		end
	end

	assign m_tvalid = valid_s5;
	assign m_tdata  = tes_pkg::OUT_DATA_W'({pay_s5.tag, pay_s5.status, pay_s5.codes,
		pay_s5.bbox_y, pay_s5.bbox_x, inv_det, pay_s5.c2, pay_s5.b2, pay_s5.c1, pay_s5.b1,
		pay_s5.c0, pay_s5.b0});

endmodule
